// ----- rtl/torq_pkg.sv -----
// ----------------------------------------------------------------------------
// torq_pkg
// Shared types and constants for the timestamp-ordered request queue.
// ----------------------------------------------------------------------------
package torq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 16;
    localparam int ID_W        = 8;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt FULL_CNT = t_cnt'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_CUT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // id in the upper bits, timestamp in the lower bits
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        t_action action;
        t_entry  key;
    } t_cmd;

    typedef struct packed {
        t_status status;
        t_entry  entry;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ENQ,
        S_PUT,
        S_SCAN,
        S_SHIFT,
        S_PEEK,
        S_FIN
    } t_state;

    // true when a sorts strictly behind b (time first, then id)
    function automatic logic key_after(input t_entry a, input t_entry b);
        return {a.stamp, a.id} > {b.stamp, b.id};
    endfunction

endpackage

// ----- rtl/torq_core.sv -----
// ----------------------------------------------------------------------------
// torq_core
// Sorted entry memory and the sequencer that inserts, removes and searches.
// ----------------------------------------------------------------------------
module torq_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  torq_pkg::t_cmd    i_cmd,
    output logic              o_idle,
    output logic              o_res_valid,
    output torq_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import torq_pkg::*;

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_idx    r_idx, n_idx;
    t_cnt    r_cnt, n_cnt;
    t_result r_res, n_res;
    t_entry  r_rdata;

    t_entry  mem [QUEUE_DEPTH];

    logic    mem_re, mem_we;
    t_idx    mem_ra, mem_wa;
    t_entry  mem_wd;

    t_cnt    idx_p1, idx_p2;
    logic    scan_last, shift_last, hit, move_up;

    assign idx_p1     = t_cnt'(r_idx) + t_cnt'(1);
    assign idx_p2     = t_cnt'(r_idx) + t_cnt'(2);
    assign scan_last  = (idx_p1 == r_cnt);
    assign shift_last = (idx_p2 == r_cnt);
    assign hit        = (r_cmd.action == ACT_DEQ) || (r_rdata.id == r_cmd.key.id);
    assign move_up    = key_after(r_rdata, r_cmd.key);

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_START;
            end
            S_START: begin
                case (r_cmd.action)
                    ACT_ENQ: begin
                        if (r_cnt == FULL_CNT || r_cnt == '0) n_state = S_FIN;
                        else n_state = S_ENQ;
                    end
                    ACT_PEEK: begin
                        if (r_cnt == '0) n_state = S_FIN;
                        else n_state = S_PEEK;
                    end
                    default: begin
                        if (r_cnt == '0) n_state = S_FIN;
                        else n_state = S_SCAN;
                    end
                endcase
            end
            S_ENQ: begin
                if (!move_up) n_state = S_FIN;
                else if (r_idx == t_idx'(1)) n_state = S_PUT;
            end
            S_PUT:  n_state = S_FIN;
            S_SCAN: begin
                if (scan_last) n_state = S_FIN;
                else if (hit) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (shift_last) n_state = S_FIN;
            end
            S_PEEK: n_state = S_FIN;
            S_FIN: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd  = r_cmd;
        n_idx  = r_idx;
        n_cnt  = r_cnt;
        n_res  = r_res;
        mem_re = 1'b0;
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = r_cmd.key;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_cmd = i_cmd;
            end
            S_START: begin
                n_res = '{status: ST_OK, entry: '0};
                case (r_cmd.action)
                    ACT_ENQ: begin
                        if (r_cnt == FULL_CNT) begin
                            n_res.status = ST_FULL;
                        end else if (r_cnt == '0) begin
                            mem_we = 1'b1;
                            mem_wa = '0;
                            n_cnt  = r_cnt + t_cnt'(1);
                        end else begin
                            mem_re = 1'b1;
                            mem_ra = t_idx'(r_cnt - t_cnt'(1));
                            n_idx  = t_idx'(r_cnt);
                        end
                    end
                    default: begin
                        if (r_cnt == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            mem_re = 1'b1;
                            mem_ra = '0;
                            n_idx  = '0;
                        end
                    end
                endcase
            end
            S_ENQ: begin
                // r_rdata holds the entry just below the hole at r_idx
                mem_we = 1'b1;
                mem_wa = r_idx;
                if (move_up) begin
                    mem_wd = r_rdata;
                    n_idx  = r_idx - t_idx'(1);
                    if (r_idx != t_idx'(1)) begin
                        mem_re = 1'b1;
                        mem_ra = r_idx - t_idx'(2);
                    end
                end else begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                n_cnt  = r_cnt + t_cnt'(1);
            end
            S_SCAN: begin
                if (hit) begin
                    n_res = '{status: ST_OK, entry: r_rdata};
                    if (scan_last) begin
                        n_cnt = r_cnt - t_cnt'(1);
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = t_idx'(idx_p1);
                    end
                end else if (scan_last) begin
                    n_res = '{status: ST_EMPTY, entry: '0};
                end else begin
                    mem_re = 1'b1;
                    mem_ra = t_idx'(idx_p1);
                    n_idx  = t_idx'(idx_p1);
                end
            end
            S_SHIFT: begin
                // r_rdata holds entry r_idx+1, moved down one slot
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_rdata;
                n_idx  = t_idx'(idx_p1);
                if (shift_last) begin
                    n_cnt = r_cnt - t_cnt'(1);
                end else begin
                    mem_re = 1'b1;
                    mem_ra = t_idx'(idx_p2);
                end
            end
            S_PEEK: begin
                n_res = '{status: ST_OK, entry: r_rdata};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("fill count above depth");

    a_no_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && mem_wa == mem_ra))
        else $error("read and write hit the same slot");

    a_idx_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (t_cnt'(r_idx) < r_cnt))
        else $error("scan index beyond fill");

    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_res.status == ST_FULL) |-> (r_cnt == FULL_CNT))
        else $error("full reported with free slots");

endmodule

// ----- rtl/timestamp_ordered_request_queue_top.sv -----
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue_top
// Request queue kept sorted by timestamp then requester id, in one memory.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                    Contents
//  s_axis   in   tvalid/tready/tdata/tuser  tuser: action; tdata: req_time, req_id
//  m_axis   out  tvalid/tready/tdata/tuser  tuser: status; tdata: out_time, out_id
//
//  One word at a time: s_axis_tready is high only while the sequencer is idle.
//  Empty, full and enqueue into an empty queue go straight to the result; peek
//  reads the head; enqueue moves each later entry back one slot; dequeue and
//  cut scan from the head and shift the rest down. The next word is taken after
//  the result registers. The single entry memory has one read, one write a cycle.
//  Sync active-low reset empties the queue; slot contents are not cleared.
//  A result waits in the output register while the next word is taken; the
//  sequencer holds its result while that register is still full.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] req_time, [23:16] req_id
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] out_time, [23:16] out_id
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import torq_pkg::*;

    logic    core_idle, core_start, core_res_valid, core_res_ready;
    t_cmd    core_cmd;
    t_result core_res;

    logic    r_m_valid, n_m_valid;
    t_result r_m_res;

    assign s_axis_tready = core_idle;
    assign core_start    = s_axis_tvalid && core_idle;

    // tdata is laid out exactly as t_entry
    assign core_cmd.action = t_action'(s_axis_tuser);
    assign core_cmd.key    = t_entry'(s_axis_tdata);

    torq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (core_start),
        .i_cmd       (core_cmd),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .i_res_ready (core_res_ready)
    );

    // output register: free when empty or drained this cycle
    assign core_res_ready = !r_m_valid || m_axis_tready;

    always_comb begin
        n_m_valid = r_m_valid;
        if (core_res_valid && core_res_ready) n_m_valid = 1'b1;
        else if (m_axis_tready) n_m_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid && core_res_ready) begin
            r_m_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_res.entry;
    assign m_axis_tuser  = r_m_res.status;

endmodule

// ----- tb/tb_timestamp_ordered_request_queue_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_ordered_request_queue_top
// Self-checking bench for the timestamp-ordered request queue: a clocked
// driver feeds request words from a backlog, a behavioral queue predicts
// every response, and a clocked monitor compares each response word.
// ----------------------------------------------------------------------------
module tb_timestamp_ordered_request_queue_top;
    import torq_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASE_REQUESTS = 300;   // random words per idle/stall phase
    localparam int DRAIN_CYCLES   = 40;
    localparam int QUIET_LIMIT    = 5000;  // cycles without any handshake
    localparam int REPORT_MAX     = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [15:0] req_time, [23:16] req_id
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] out_time, [23:16] out_id
    logic [1:0]  m_axis_tuser;          // [1:0] status

    timestamp_ordered_request_queue_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Request words waiting to be driven, and responses the queue owes us.
    // t_cmd packs {action, id, stamp}, which is exactly {tuser, tdata};
    // t_result packs {status, id, stamp}, which is {tuser, tdata} on the
    // response side.
    t_cmd    request_backlog[$];
    t_result due_responses[$];

    // Behavioral copy of the sorted queue, head at index 0.
    t_entry  sorted_slots[QUEUE_DEPTH];
    int      sorted_fill = 0;

    // Idle and stall odds in percent, changed per phase.
    int      idle_pct  = 0;
    int      stall_pct = 0;

    int      planned_requests = 0;
    int      responses_seen   = 0;
    int      mismatches       = 0;
    int      action_count[4]  = '{0, 0, 0, 0};
    int      full_refusals    = 0;
    int      empty_replies    = 0;
    int      peak_fill        = 0;
    int      quiet_cycles     = 0;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Response predictor: applies one accepted request to the behavioral
    // queue and queues up the response it must produce.
    // ------------------------------------------------------------------------
    task automatic predict_response(input t_cmd req);
        t_result res;
        int      pos;
        int      take;
        int      k;
        res.status = ST_OK;
        res.entry  = '0;
        take       = -1;
        action_count[req.action]++;
        case (req.action)
            ACT_ENQ: begin
                if (sorted_fill >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // goes behind every entry with key <= its own, so equal
                    // keys keep arrival order
                    pos = 0;
                    while (pos < sorted_fill &&
                           {sorted_slots[pos].stamp, sorted_slots[pos].id} <=
                           {req.key.stamp, req.key.id})
                        pos++;
                    for (k = sorted_fill; k > pos; k--)
                        sorted_slots[k] = sorted_slots[k - 1];
                    sorted_slots[pos] = req.key;
                    sorted_fill++;
                end
            end
            ACT_DEQ: begin
                if (sorted_fill == 0) res.status = ST_EMPTY;
                else take = 0;
            end
            ACT_PEEK: begin
                if (sorted_fill == 0) res.status = ST_EMPTY;
                else res.entry = sorted_slots[0];
            end
            ACT_CUT: begin
                // first match in queue order; timestamp of the request ignored
                pos = 0;
                while (pos < sorted_fill && sorted_slots[pos].id != req.key.id)
                    pos++;
                if (pos == sorted_fill) res.status = ST_EMPTY;
                else take = pos;
            end
            default: ;
        endcase
        if (take >= 0) begin
            res.entry = sorted_slots[take];
            for (k = take; k < sorted_fill - 1; k++)
                sorted_slots[k] = sorted_slots[k + 1];
            sorted_fill--;
        end
        if (res.status == ST_FULL) full_refusals++;
        if (res.status == ST_EMPTY) empty_replies++;
        if (sorted_fill > peak_fill) peak_fill = sorted_fill;
        due_responses.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Driver: predicts on each accepted word, then loads the next word from
    // the backlog whenever the bus slot is free and the idle dice allow.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_response(t_cmd'({s_axis_tuser, s_axis_tdata}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt            = request_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.key;
                    s_axis_tuser  <= nxt.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every accepted response word against the oldest
    // prediction, field by field, and throttles tready at random.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'({m_axis_tuser, m_axis_tdata});
                responses_seen++;
                if (due_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: response with none pending: status %0d time %h id %h",
                                 $realtime, got.status, got.entry.stamp, got.entry.id);
                end else begin
                    want = due_responses.pop_front();
                    if (got.status != want.status || got.entry.stamp != want.entry.stamp ||
                        got.entry.id != want.entry.id) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"%0t: response %0d: expected status %0d time %h id %h,",
                                      " got status %0d time %h id %h"},
                                     $realtime, responses_seen, want.status, want.entry.stamp,
                                     want.entry.id, got.status, got.entry.stamp, got.entry.id);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a handshake on either side means a hang.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d quiet cycles, %0d responses outstanding",
                     quiet_cycles, due_responses.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_request(input t_action act, input t_entry key);
        t_cmd c;
        c.action = act;
        c.key    = key;
        request_backlog.push_back(c);
        planned_requests++;
    endtask

    // Tight keys come from a small pool so that ties and cut hits are common;
    // loose keys span all bits.
    function automatic t_entry rand_key(input bit tight);
        t_entry e;
        if (tight) begin
            e.stamp = $urandom_range(1) ? 16'($urandom_range(7))
                                        : 16'hFFF8 + 16'($urandom_range(7));
            e.id    = $urandom_range(3) != 0 ? 8'($urandom_range(7))
                                             : 8'hFC + 8'($urandom_range(3));
        end else begin
            e.stamp = 16'($urandom_range(16'hFFFF));
            e.id    = 8'($urandom_range(8'hFF));
        end
        return e;
    endfunction

    // One burst: a fill run of enqueues and peeks (it can run long enough to
    // overflow), a drain run of dequeues, cuts and peeks, or a stretch of arbitrary words.
    task automatic add_random_burst();
        int mode;
        int n;
        int pick;
        mode = $urandom_range(9);
        n    = $urandom_range(1, 20);
        if (mode < 4) begin
            repeat (n)
                if ($urandom_range(3) == 0) add_request(ACT_PEEK, rand_key(1'b0));
                else add_request(ACT_ENQ, rand_key(1'($urandom_range(1))));
        end else if (mode < 7) begin
            repeat (n) begin
                pick = $urandom_range(19);
                if (pick < 9) add_request(ACT_DEQ, rand_key(1'b0));
                else if (pick < 17) add_request(ACT_CUT, rand_key(pick != 16));
                else add_request(ACT_PEEK, rand_key(1'b0));
            end
        end else begin
            repeat ((n + 1) / 2)
                add_request(t_action'($urandom_range(3)),
                            rand_key(1'($urandom_range(1))));
        end
    endtask

    task automatic add_directed_requests();
        // empty queue: every read-type action reports empty / not found
        add_request(ACT_PEEK, '{id: 8'hA5, stamp: 16'h5A5A});
        add_request(ACT_DEQ,  '{id: 8'hFF, stamp: 16'hFFFF});
        add_request(ACT_CUT,  '{id: 8'h00, stamp: 16'h0000});
        // field extremes, a secondary-key tie and a repeated key
        add_request(ACT_ENQ,  '{id: 8'hFF, stamp: 16'hFFFF});
        add_request(ACT_ENQ,  '{id: 8'h00, stamp: 16'h0000});
        add_request(ACT_ENQ,  '{id: 8'h05, stamp: 16'h1234});
        add_request(ACT_ENQ,  '{id: 8'h03, stamp: 16'h1234});
        add_request(ACT_ENQ,  '{id: 8'h05, stamp: 16'h1234});
        add_request(ACT_PEEK, '{id: 8'h5A, stamp: 16'hA5A5});
        // cut takes the first id 5 in queue order; stamp in the word is don't care
        add_request(ACT_CUT,  '{id: 8'h05, stamp: 16'hFFFF});
        add_request(ACT_CUT,  '{id: 8'h77, stamp: 16'h0000});
        add_request(ACT_DEQ,  '{id: 8'h00, stamp: 16'h0000});
        // three left; fill to the brim, then one more must be refused
        for (int i = 0; i < QUEUE_DEPTH - 3; i++)
            add_request(ACT_ENQ, '{id: 8'(i), stamp: 16'hFFFF - 16'(i)});
        add_request(ACT_ENQ,  '{id: 8'h80, stamp: 16'h8000});
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        int target;
        phase_idle  = '{0, 49, 0, 38};
        phase_stall = '{0, 0, 49, 38};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            if (ph == 0) add_directed_requests();
            target = planned_requests + PHASE_REQUESTS;
            while (planned_requests < target) add_random_burst();
            // let the phase drain completely before changing the odds
            while (request_backlog.size() != 0 || s_axis_tvalid || due_responses.size() != 0)
                @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d enq, %0d deq, %0d peek, %0d cut), %0d checked",
                 planned_requests, action_count[ACT_ENQ], action_count[ACT_DEQ],
                 action_count[ACT_PEEK], action_count[ACT_CUT], responses_seen);
        $display("Queue peaked at %0d of %0d entries; %0d full refusals, %0d empty replies",
                 peak_fill, QUEUE_DEPTH, full_refusals, empty_replies);
        if (mismatches == 0 && due_responses.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d responses never seen", mismatches,
                     due_responses.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
